/* design/gpe_pkg.sv */
// Package for the game controller poll-frame master.
// Holds the op codes, protocol bytes, frame positions and the result record.
// No dependencies; used by gamepad_poll_edge_detect_top.
package gpe_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_VIB   = 2'd1,
        OP_START = 2'd2,
        OP_XCHG  = 2'd3
    } op_t;

    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_POLL  = 8'h42;
    localparam logic [7:0] CMD_ZERO  = 8'h00;
    localparam logic [7:0] MODE_DIG  = 8'h41;
    localparam logic [7:0] MODE_ANA  = 8'h73;
    localparam logic [7:0] HDR_OK    = 8'h5A;
    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    localparam logic [7:0] AXIS_MID_RESET = 8'd128;

    localparam logic [3:0] POS_NONE   = 4'd0;
    localparam logic [3:0] POS_POLL   = 4'd1;
    localparam logic [3:0] POS_MODE   = 4'd2;
    localparam logic [3:0] POS_HDR    = 4'd3;
    localparam logic [3:0] POS_BTN_LO = 4'd4;
    localparam logic [3:0] POS_BTN_HI = 4'd5;
    localparam logic [3:0] POS_AXIS0  = 4'd6;
    localparam logic [3:0] POS_AXIS1  = 4'd7;
    localparam logic [3:0] POS_AXIS2  = 4'd8;
    localparam logic [3:0] POS_AXIS3  = 4'd9;

    localparam int REG_ANALOG_MID = 0;

    typedef struct packed {
        logic [7:0]  left_y;
        logic [7:0]  left_x;
        logic [7:0]  right_y;
        logic [7:0]  right_x;
        logic [15:0] released;
        logic [15:0] pressed;
        logic [15:0] buttons;
        logic [7:0]  cmd_byte;
        logic        frame_end;
        logic        success;
    } result_t;

endpackage

/* design/gamepad_poll_edge_detect_top.sv */
// Game controller poll-frame master: top level.
// Throughput: one request per cycle while the skid buffer is empty; the output
// register plus a one-entry skid buffer let a request enter while the previous
// result waits downstream.
// Reset (rst_n, async, active low): no frame open, buttons all ones, masks clear,
// axes and analog_mid at 128, motors off, output and skid empty.
module gamepad_poll_edge_detect_top
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // resp_byte, small_motor, large_motor, duration_steps
    input  logic [1:0]  s_tuser,   // op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // cmd_byte, buttons, pressed, released,
                                   // right_x, right_y, left_x, left_y
    output logic        m_tuser,   // success
    output logic        m_tlast,   // frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration register
    logic [7:0] analog_mid_reg;
    logic       cfg_wr;
    logic       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (32'(paddr[2]) == gpe_pkg::REG_ANALOG_MID);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? {24'd0, analog_mid_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            analog_mid_reg <= gpe_pkg::AXIS_MID_RESET;
        else if (cfg_wr)
            analog_mid_reg <= pwdata[7:0];
    end

    // request fields
    gpe_pkg::op_t op;
    logic [7:0]   resp_byte;
    logic [7:0]   small_motor;
    logic [7:0]   large_motor;
    logic [7:0]   duration_steps;

    assign op             = gpe_pkg::op_t'(s_tuser);
    assign resp_byte      = s_tdata[7:0];
    assign small_motor    = s_tdata[15:8];
    assign large_motor    = s_tdata[23:16];
    assign duration_steps = s_tdata[31:24];

    // frame and controller state
    logic        frame_open_reg,    frame_open_next;
    logic [3:0]  frame_pos_reg,     frame_pos_next;
    logic [7:0]  mode_seen_reg,     mode_seen_next;
    logic [7:0]  header_seen_reg,   header_seen_next;
    logic [15:0] button_state_reg,  button_state_next;
    logic [15:0] last_buttons_reg,  last_buttons_next;
    logic [15:0] pressed_mask_reg,  pressed_mask_next;
    logic [15:0] released_mask_reg, released_mask_next;
    logic [7:0]  axis_reg [4];
    logic [7:0]  axis_next [4];
    logic        vib_small_reg,     vib_small_next;
    logic [7:0]  vib_large_reg,     vib_large_next;
    logic [7:0]  vib_count_reg,     vib_count_next;

    gpe_pkg::result_t res_next;
    gpe_pkg::result_t out_reg;
    gpe_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             accept;
    logic             take;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;

    always_comb
    begin
        logic mode_ok;
        logic finish;
        logic ok;
        logic [7:0] cmd;

        frame_open_next    = frame_open_reg;
        frame_pos_next     = frame_pos_reg;
        mode_seen_next     = mode_seen_reg;
        header_seen_next   = header_seen_reg;
        button_state_next  = button_state_reg;
        last_buttons_next  = last_buttons_reg;
        pressed_mask_next  = pressed_mask_reg;
        released_mask_next = released_mask_reg;
        for (int i = 0; i < 4; i++)
            axis_next[i] = axis_reg[i];
        vib_small_next     = vib_small_reg;
        vib_large_next     = vib_large_reg;
        vib_count_next     = vib_count_reg;

        mode_ok = (mode_seen_reg == gpe_pkg::MODE_DIG) || (mode_seen_reg == gpe_pkg::MODE_ANA);
        finish  = 1'b0;
        ok      = 1'b0;
        cmd     = gpe_pkg::IDLE_BYTE;

        case (op)
            gpe_pkg::OP_TICK:
            begin
                if (vib_count_reg != 8'd0)
                begin
                    vib_count_next = vib_count_reg - 8'd1;
                    if (vib_count_reg == 8'd1)
                    begin
                        vib_small_next = 1'b0;
                        vib_large_next = 8'd0;
                    end
                end
            end
            gpe_pkg::OP_VIB:
            begin
                vib_small_next = (small_motor != 8'd0);
                vib_large_next = large_motor;
                vib_count_next = duration_steps;
            end
            gpe_pkg::OP_START:
            begin
                frame_open_next  = 1'b1;
                frame_pos_next   = gpe_pkg::POS_POLL;
                mode_seen_next   = 8'd0;
                header_seen_next = 8'd0;
                cmd              = gpe_pkg::CMD_START;
            end
            default:
            begin
                if (frame_open_reg)
                begin
                    case (frame_pos_reg)
                        gpe_pkg::POS_POLL:
                        begin
                            cmd            = gpe_pkg::CMD_POLL;
                            frame_pos_next = gpe_pkg::POS_MODE;
                        end
                        gpe_pkg::POS_MODE:
                        begin
                            mode_seen_next = resp_byte;
                            cmd            = gpe_pkg::CMD_ZERO;
                            frame_pos_next = gpe_pkg::POS_HDR;
                        end
                        gpe_pkg::POS_HDR:
                        begin
                            header_seen_next = resp_byte;
                            if (mode_ok)
                            begin
                                cmd            = {7'd0, vib_small_reg};
                                frame_pos_next = gpe_pkg::POS_BTN_LO;
                            end
                            else
                                finish = 1'b1;  // bad mode never succeeds
                        end
                        gpe_pkg::POS_BTN_LO:
                        begin
                            button_state_next = {button_state_reg[15:8], resp_byte};
                            cmd               = vib_large_reg;
                            frame_pos_next    = gpe_pkg::POS_BTN_HI;
                        end
                        gpe_pkg::POS_BTN_HI:
                        begin
                            button_state_next = {resp_byte, button_state_reg[7:0]};
                            if (mode_seen_reg == gpe_pkg::MODE_DIG)
                            begin
                                for (int i = 0; i < 4; i++)
                                    axis_next[i] = analog_mid_reg;
                                finish = 1'b1;
                                ok     = (header_seen_reg == gpe_pkg::HDR_OK);
                            end
                            else
                            begin
                                cmd            = gpe_pkg::CMD_ZERO;
                                frame_pos_next = gpe_pkg::POS_AXIS0;
                            end
                        end
                        gpe_pkg::POS_AXIS0, gpe_pkg::POS_AXIS1, gpe_pkg::POS_AXIS2:
                        begin
                            axis_next[frame_pos_reg[1:0] - 2'd2] = resp_byte;
                            cmd            = gpe_pkg::CMD_ZERO;
                            frame_pos_next = frame_pos_reg + 4'd1;
                        end
                        gpe_pkg::POS_AXIS3:
                        begin
                            axis_next[3] = resp_byte;
                            finish       = 1'b1;
                            ok           = mode_ok && (header_seen_reg == gpe_pkg::HDR_OK);
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        if (finish)
        begin
            frame_open_next = 1'b0;
            frame_pos_next  = gpe_pkg::POS_NONE;
        end
        if (ok)
        begin
            pressed_mask_next  = ~button_state_next & last_buttons_reg;
            released_mask_next = button_state_next & ~last_buttons_reg;
            last_buttons_next  = button_state_next;
        end

        res_next.cmd_byte  = cmd;
        res_next.frame_end = !frame_open_next;
        res_next.success   = ok;
        res_next.buttons   = button_state_next;
        res_next.pressed   = pressed_mask_next;
        res_next.released  = released_mask_next;
        res_next.right_x   = axis_next[0];
        res_next.right_y   = axis_next[1];
        res_next.left_x    = axis_next[2];
        res_next.left_y    = axis_next[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg    <= 1'b0;
            frame_pos_reg     <= gpe_pkg::POS_NONE;
            mode_seen_reg     <= 8'd0;
            header_seen_reg   <= 8'd0;
            button_state_reg  <= 16'hFFFF;
            last_buttons_reg  <= 16'hFFFF;
            pressed_mask_reg  <= 16'd0;
            released_mask_reg <= 16'd0;
            for (int i = 0; i < 4; i++)
                axis_reg[i] <= gpe_pkg::AXIS_MID_RESET;
            vib_small_reg     <= 1'b0;
            vib_large_reg     <= 8'd0;
            vib_count_reg     <= 8'd0;
        end
        else if (accept)
        begin
            frame_open_reg    <= frame_open_next;
            frame_pos_reg     <= frame_pos_next;
            mode_seen_reg     <= mode_seen_next;
            header_seen_reg   <= header_seen_next;
            button_state_reg  <= button_state_next;
            last_buttons_reg  <= last_buttons_next;
            pressed_mask_reg  <= pressed_mask_next;
            released_mask_reg <= released_mask_next;
            for (int i = 0; i < 4; i++)
                axis_reg[i] <= axis_next[i];
            vib_small_reg     <= vib_small_next;
            vib_large_reg     <= vib_large_next;
            vib_count_reg     <= vib_count_next;
        end
    end

    // output register with one-entry skid buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res_next;
        end
        else if (accept)
            skid_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.left_y, out_reg.left_x, out_reg.right_y, out_reg.right_x,
                       out_reg.released, out_reg.pressed, out_reg.buttons, out_reg.cmd_byte};
    assign m_tuser  = out_reg.success;
    assign m_tlast  = out_reg.frame_end;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_success_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.success) |-> out_reg.frame_end)
        else $error("success reported on an open frame");

    a_frame_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> (frame_pos_reg >= gpe_pkg::POS_POLL) &&
                           (frame_pos_reg <= gpe_pkg::POS_AXIS3))
        else $error("open frame with position out of range");

    a_closed_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> (frame_pos_reg == gpe_pkg::POS_NONE))
        else $error("closed frame with nonzero position");
`endif

endmodule
